### rtl/lhp_pkg.sv
// Shared types and constants for the luminance histogram with peak tracking.
// Used by every module of the block; depends on nothing else.
package lhp_pkg;

   // Histogram geometry and count range.
   localparam int NUM_BINS    = 256;
   localparam int BIN_W       = 8;
   localparam int CNT_W       = 23;
   localparam int COUNT_LIMIT = 4194304;

   // Luminance weights 0.289, 0.5556 and 0.112 in 16-bit fixed point.
   localparam int SUM_W     = 24;
   localparam int LUM_SHIFT = 16;
   localparam logic [SUM_W-1:0] W_RED   = SUM_W'(18940);
   localparam logic [SUM_W-1:0] W_GREEN = SUM_W'(36411);
   localparam logic [SUM_W-1:0] W_BLUE  = SUM_W'(7340);

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Operation codes.
   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [BIN_W-1:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0] bin_number;
      logic [CNT_W-1:0] bin_count;
      logic [CNT_W-1:0] peak_count;
   } rsp_type;

   // One classified command as the back executes it.
   typedef struct packed {
      logic [1:0]       op;
      logic [BIN_W-1:0] bin;
   } cmd_type;

endpackage

### rtl/luma_histogram_with_peak_core.sv
// Top level of the luminance histogram with peak tracking.
// Depends on lhp_pkg, lhp_front, lhp_fifo and lhp_back.
//
// Each request beat gives exactly one response beat. Op 0 adds an RGB pixel
// to the bin at its luminance (18940*R + 36411*G + 7340*B) >> 16, saturating
// at 4194304, and returns that bin, its new count and the peak; op 1 returns
// one bin and the peak; op 2 clears all bins and the peak in one step and
// returns zeros; op 3 returns zeros. The back end reads the bin memory when
// it takes a command, writes it in its execute state and takes no new one
// until idle. A request passes the front stage, queue, read registers and
// result register. The front end and the two-entry queue accept beats while
// a response waits. No clearing pass is needed after reset.
module luma_histogram_with_peak_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lhp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lhp_pkg::rsp_type rsp_data
);

   logic             front_valid, front_ready;
   lhp_pkg::cmd_type front_cmd;
   logic             queue_valid, queue_ready;
   lhp_pkg::cmd_type queue_cmd;

   lhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd_data  (front_cmd)
   );

   lhp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   lhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // No bin can exceed the peak that is kept alongside it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bin_count <= rsp_data.peak_count)
      else $error("bin count above peak");

   // Counts saturate at the limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.peak_count <= lhp_pkg::CNT_W'(lhp_pkg::COUNT_LIMIT))
      else $error("peak above count limit");
`endif

endmodule

### rtl/lhp_front.sv
// Front end: accepts request beats, computes the pixel luminance and turns each
// beat into a command for the back. Depends on lhp_pkg.
module lhp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lhp_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output lhp_pkg::cmd_type cmd_data
);

   logic                       stage_valid_ff, stage_valid_in;
   logic [1:0]                 op_ff;
   logic [lhp_pkg::BIN_W-1:0]  bin_index_ff;
   logic [lhp_pkg::SUM_W-1:0]  prod_r_ff, prod_g_ff, prod_b_ff;
   logic [lhp_pkg::SUM_W-1:0]  luma_sum;
   logic                       accept;

   // The stage takes a new beat when empty or when its command moves on.
   assign req_ready = !stage_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (cmd_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Weighted color products are registered before the sum.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_data.op;
         bin_index_ff <= req_data.bin_index;
         prod_r_ff    <= lhp_pkg::SUM_W'(req_data.red) * lhp_pkg::W_RED;
         prod_g_ff    <= lhp_pkg::SUM_W'(req_data.green) * lhp_pkg::W_GREEN;
         prod_b_ff    <= lhp_pkg::SUM_W'(req_data.blue) * lhp_pkg::W_BLUE;
      end
   end

   // The sum never exceeds 24 bits, so the bin is the byte above the fraction.
   assign luma_sum = prod_r_ff + prod_g_ff + prod_b_ff;

   assign cmd_valid   = stage_valid_ff;
   assign cmd_data.op = op_ff;
   assign cmd_data.bin = (op_ff == lhp_pkg::OP_ACCUM)
                         ? luma_sum[lhp_pkg::LUM_SHIFT +: lhp_pkg::BIN_W]
                         : bin_index_ff;

endmodule

### rtl/lhp_fifo.sv
// Short command queue between the front and the back of the histogram.
// Depends on lhp_pkg for the command type and the depth.
module lhp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lhp_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lhp_pkg::cmd_type pop_data
);

   lhp_pkg::cmd_type                entry_ff [lhp_pkg::QUEUE_DEPTH];
   logic [lhp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lhp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lhp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            push, pop;

   assign push_ready = count_ff != lhp_pkg::QUEUE_CNT_W'(lhp_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointers wrap naturally because the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/lhp_back.sv
// Back end: executes accumulate, read and clear commands on the bin memory and
// keeps the running peak. Depends on lhp_pkg.
module lhp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  lhp_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lhp_pkg::rsp_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   localparam logic [lhp_pkg::CNT_W-1:0] LIMIT = lhp_pkg::CNT_W'(lhp_pkg::COUNT_LIMIT);

   logic [lhp_pkg::CNT_W-1:0]    bin_mem [lhp_pkg::NUM_BINS];
   logic [lhp_pkg::NUM_BINS-1:0] bin_valid_ff, bin_valid_in;
   logic                         state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lhp_pkg::CNT_W-1:0]    peak_ff, peak_in;
   lhp_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [1:0]                   op_ff;
   logic [lhp_pkg::BIN_W-1:0]    bin_ff;
   logic [lhp_pkg::CNT_W-1:0]    rd_data_ff;
   logic                         rd_hit_ff;
   logic                         take, exec, mem_write;
   logic [lhp_pkg::CNT_W-1:0]    cur_cnt, inc_cnt, inc_peak;

   // A command is taken only when idle and the result register is free.
   assign cmd_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = cmd_valid && cmd_ready;
   assign exec      = state_ff == ST_EXEC;

   // Bin read happens on take; an entry not written since clear reads as zero.
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff      <= cmd_data.op;
         bin_ff     <= cmd_data.bin;
         rd_data_ff <= bin_mem[cmd_data.bin];
         rd_hit_ff  <= bin_valid_ff[cmd_data.bin];
      end
   end

   // Saturating increment and peak update.
   assign cur_cnt  = rd_hit_ff ? rd_data_ff : '0;
   assign inc_cnt  = (cur_cnt < LIMIT) ? cur_cnt + 1'b1 : cur_cnt;
   assign inc_peak = (inc_cnt > peak_ff) ? inc_cnt : peak_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      peak_in      = peak_ff;
      bin_valid_in = bin_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_write    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         state_in = ST_EXEC;
      end
      if (exec) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         case (op_ff)
            lhp_pkg::OP_ACCUM: begin
               mem_write            = 1'b1;
               bin_valid_in[bin_ff] = 1'b1;
               peak_in              = inc_peak;
               rsp_data_in.bin_number = bin_ff;
               rsp_data_in.bin_count  = inc_cnt;
               rsp_data_in.peak_count = inc_peak;
            end
            lhp_pkg::OP_READ: begin
               rsp_data_in.bin_number = bin_ff;
               rsp_data_in.bin_count  = cur_cnt;
               rsp_data_in.peak_count = peak_ff;
            end
            lhp_pkg::OP_CLEAR: begin
               bin_valid_in = '0;
               peak_in      = '0;
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= '0;
         bin_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         bin_valid_ff <= bin_valid_in;
      end
   end

   // Result payload and bin memory need no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (mem_write) begin
         bin_mem[bin_ff] <= inc_cnt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
